[hdl/qkr_pkg.sv]
// ----------------------------------------------------------------------------
// qkr_pkg : shared types and constants for the keyed-removal queue
// Entry layout, status codes, operation codes and memory control bundle.
// ----------------------------------------------------------------------------
package qkr_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_W            = 16;
   localparam int VAL_W           = 32;
   localparam int STATUS_W        = 3;
   localparam int OCC_W           = 5;
   localparam int REQ_DATA_W      = ID_W + VAL_W;        // 48, whole bytes
   localparam int RSP_DATA_W      = 40;                  // 5 + 32 padded to bytes

   // operation codes carried on req_tuser
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [ID_W-1:0]  id;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

[hdl/qkr_mem.sv]
// ----------------------------------------------------------------------------
// qkr_mem : entry store of the keyed-removal queue
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module qkr_mem
   import qkr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int AW          = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  mem_ctl_type   ctl,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type store_mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fifo_queue_with_keyed_removal.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_keyed_removal : ordered queue with removal by identifier
// Sequence: an insert, full or empty transaction goes from S_IDLE to S_RESP,
//   which loads the response register; a remove scans the held entries in
//   S_SEARCH, moves any entries behind the hit down in S_SHIFT, then S_RESP.
// Transactions: one at a time; the next request is taken only once the
//   previous transaction has loaded its response, which waits while an
//   earlier response is still not taken. The scan and the move go one
//   entry per cycle through the memory's read and write ports.
// Reset: synchronous, active high; empties the queue and drops any pending
//   response. Memory contents are not cleared, as only held entries are read.
// ----------------------------------------------------------------------------
module fifo_queue_with_keyed_removal
   import qkr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] entry_id, [47:16] entry_value
   input  logic                  req_tuser,   // [0] func
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [4:0] occupancy, [36:5] removed_value,
                                              // [39:37] zero
   output logic [STATUS_W-1:0]   rsp_tuser    // [2:0] status
);

   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);   // holds 0..QUEUE_DEPTH
   localparam int CW1 = CW + 1;                    // headroom for look-ahead sums

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    pos_ff, pos_in;          // scan position, then shift write pointer
   logic [ID_W-1:0]  key_ff, key_in;
   status_type       res_status_ff, res_status_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
   entry_type        mem_wr_data, mem_rd_data;

   logic             req_accept;
   logic             rsp_load;
   logic             key_hit;
   logic [CW1-1:0]   pos_plus1, pos_plus2, count_wide;

   entry_type        req_entry;

   assign req_entry  = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;

   assign count_wide = {1'b0, count_ff};
   assign pos_plus1  = {1'b0, pos_ff} + CW1'(1);
   assign pos_plus2  = {1'b0, pos_ff} + CW1'(2);
   assign key_hit    = (mem_rd_data.id == key_ff);

   // the response slot is free when empty or being drained this cycle
   assign rsp_load = (state_ff == S_RESP) & (~rsp_valid_ff | rsp_tready);

   // ---------------------------------------------------------------------
   // Sequencer: scan the memory from the head, then move the tail down.
   // Reads run two entries ahead of writes during the shift, so a read and a
   // write never meet at the same address; a new transaction is only taken
   // once the previous one has finished with the memory.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;

      mem_ctl       = '0;
      mem_wr_addr   = AW'(count_ff);
      mem_wr_data   = req_entry;
      mem_rd_addr   = AW'(pos_plus1);

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in       = req_entry.id;
               res_value_in = '0;
               case (req_tuser)
                  FUNC_INSERT: begin
                     state_in = S_RESP;
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // append at the tail
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CW'(1);
                        res_status_in = ST_INSERTED;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        // fetch the head entry
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = '0;
                        pos_in        = '0;
                        state_in      = S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            // read data belongs to pos_ff; prefetch the next entry
            mem_ctl.rd_en = 1'b1;
            if (key_hit) begin
               res_status_in = ST_REMOVED;
               res_value_in  = mem_rd_data.value;
               if (pos_plus1 < count_wide) begin
                  state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_RESP;
               end
            end else if (pos_plus1 < count_wide) begin
               pos_in = CW'(pos_plus1);
            end else begin
               res_status_in = ST_NOT_FOUND;
               res_value_in  = '0;
               state_in      = S_RESP;
            end
         end

         S_SHIFT: begin
            // move entry pos_ff + 1 into pos_ff, prefetch pos_ff + 2
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = AW'(pos_ff);
            mem_wr_data   = mem_rd_data;
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = AW'(pos_plus2);
            pos_in        = CW'(pos_plus1);
            if (pos_plus2 >= count_wide) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register: hold until taken, refill from the result registers
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_value_in  = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_occ_in    = OCC_W'(count_ff);
         rsp_value_in  = res_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_value_ff  <= rsp_value_in;
   end

   qkr_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VAL_W - OCC_W)'(0), rsp_value_ff, rsp_occ_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> pos_ff < count_ff)
      else $error("scan position outside held entries");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> pos_plus1 < count_wide)
      else $error("shift source outside held entries");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_REMOVED |-> rsp_value_ff == '0)
      else $error("removed value set on a non-removal response");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !req_accept |=> $stable(count_ff))
      else $error("entry count moved without a transaction");
`endif

endmodule
